[rtl/core/gwtu_pkg.sv]
package gwtu_pkg;

  // Field widths
  localparam int WeekW   = 12;
  localparam int TowW    = 31;
  localparam int LeapW   = 7;
  localparam int YearW   = 12;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SecondW = 6;
  localparam int MsecW   = 10;

  // Calendar constants
  localparam int unsigned MsPerWeek  = 604800000;
  localparam int unsigned SecPerWeek = 604800;
  localparam int unsigned MsPerSec   = 1000;
  localparam int unsigned SecPerDay  = 86400;
  localparam int unsigned SecPerHour = 3600;
  localparam int unsigned SecPerMin  = 60;
  localparam int unsigned DaysPerQuad = 1461;
  localparam int unsigned DaysPerYear = 365;
  localparam int unsigned BaseYear   = 2005;
  localparam int unsigned MaxYearIdx = 3;

  // Seconds offset applied to the biased week count (one year less two weeks)
  localparam int unsigned SecBias = 30326400;

  // Reciprocals for exact constant division: q = (x * M) >> Sh, valid for x < 2**N
  localparam logic [28:0] RecipMs     = 29'd274877907; // x/125,  N=28, Sh=35
  localparam logic [25:0] RecipDay    = 26'd50903317;  // x/675,  N=25, Sh=35
  localparam logic [16:0] RecipQuad   = 17'd91868;     // x/1461, N=16, Sh=27
  localparam logic [13:0] RecipHour   = 14'd9321;      // x/225,  N=13, Sh=21
  localparam logic [10:0] RecipMin    = 11'd1093;      // x/15,   N=10, Sh=14
  localparam logic [10:0] RecipCentury = 11'd1311;     // x/25,   N=10, Sh=15

  // Cumulative days before each month, index 0 is before January
  function automatic logic [8:0] cum_days(input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

[rtl/core/gnss_week_tow_to_utc_calendar.sv]
// Converts a satellite week number and a signed time of week in milliseconds into a UTC
// calendar date and time of day, counted from 2005-01-01 with the signed leap_seconds
// register applied. The block is a ten-stage pipeline of constant-reciprocal divisions
// (ms, days, four-year blocks, hours, minutes, centuries) and takes one beat per cycle
// when in_stall is low. The user writes leap_seconds through cfg_wr_en/cfg_wr_data
// only while no beat is in flight; the block itself does not enforce this.
module gnss_week_tow_to_utc_calendar (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [gwtu_pkg::LeapW-1:0]          cfg_wr_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gwtu_pkg::WeekW-1:0]          week_number,
  input  logic signed [gwtu_pkg::TowW-1:0]    tow_ms,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gwtu_pkg::YearW-1:0]          year,
  output logic [gwtu_pkg::MonthW-1:0]         month,
  output logic [gwtu_pkg::DayW-1:0]           day_of_month,
  output logic [gwtu_pkg::HourW-1:0]          hour,
  output logic [gwtu_pkg::MinuteW-1:0]        minute,
  output logic [gwtu_pkg::SecondW-1:0]        second,
  output logic [gwtu_pkg::MsecW-1:0]          millisecond
);
  import gwtu_pkg::*;

  localparam int NumStg = 10;

  logic [NumStg-1:0] vld;
  logic [NumStg-1:0] adv;

  logic signed [LeapW-1:0] leap_seconds;

  // Leap offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      leap_seconds <= '0;
    end else if (cfg_wr_en) begin
      leap_seconds <= cfg_wr_data;
    end
  end

  // Stage advance: a stage loads when empty or when the next one moves
  always_comb begin
    adv[NumStg-1] = !vld[NumStg-1] || !out_stall;
    for (int k = NumStg - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NumStg-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Borrow a week on negative tow; bias the ms part by one week so it stays positive.
  logic               borrow;
  logic signed [32:0] u_full;
  logic [12:0]        s1_wk;
  logic [30:0]        s1_u;

  assign borrow = tow_ms[TowW-1];

  always_comb begin
    u_full = $signed({{2{tow_ms[TowW-1]}}, tow_ms})
           + (borrow ? 33'sd1209600000 : 33'sd604800000)
           + $signed({{(33-LeapW){leap_seconds[LeapW-1]}}, leap_seconds}) * 33'sd1000;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_wk <= {1'b0, week_number} + 13'd1 - {12'd0, borrow};
      s1_u  <= u_full[30:0];
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Week seconds and whole seconds of the ms part
  logic [32:0] wk_prod;
  logic [56:0] ms_prod;
  logic [31:0] s2_pw;
  logic [21:0] s2_q;
  logic [30:0] s2_u;

  assign wk_prod = 33'(s1_wk) * 33'(SecPerWeek);
  assign ms_prod = 57'(s1_u[30:3]) * 57'(RecipMs);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_pw <= wk_prod[31:0];
      s2_q  <= ms_prod[56:35];
      s2_u  <= s1_u;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Total seconds since the origin and leftover ms
  logic [31:0] q_ms;
  logic [31:0] ms_rem;
  logic [31:0] s3_secs;
  logic [MsecW-1:0] s3_ms;

  assign q_ms   = 32'(s2_q) * 32'(MsPerSec);
  assign ms_rem = {1'b0, s2_u} - q_ms;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_secs <= s2_pw + 32'(SecBias) + 32'(s2_q);
      s3_ms   <= ms_rem[MsecW-1:0];
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Day count
  logic [50:0] day_prod;
  logic [15:0] s4_days;
  logic [31:0] s4_secs;
  logic [MsecW-1:0] s4_ms;

  assign day_prod = 51'(s3_secs[31:7]) * 51'(RecipDay);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_days <= day_prod[50:35];
      s4_secs <= s3_secs;
      s4_ms   <= s3_ms;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Seconds of day and four-year block index
  logic [31:0] day_secs;
  logic [31:0] tod_full;
  logic [32:0] quad_prod;
  logic [16:0] s5_tod;
  logic [5:0]  s5_quad;
  logic [15:0] s5_days;
  logic [MsecW-1:0] s5_ms;

  assign day_secs  = 32'(s4_days) * 32'(SecPerDay);
  assign tod_full  = s4_secs - day_secs;
  assign quad_prod = 33'(s4_days) * 33'(RecipQuad);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_tod  <= tod_full[16:0];
      s5_quad <= quad_prod[32:27];
      s5_days <= s4_days;
      s5_ms   <= s4_ms;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // Day inside the block and hour
  logic [15:0] quad_days;
  logic [15:0] qd_full;
  logic [26:0] hour_prod;
  logic [10:0] s6_qd;
  logic [HourW-1:0] s6_hour;
  logic [16:0] s6_tod;
  logic [5:0]  s6_quad;
  logic [MsecW-1:0] s6_ms;

  assign quad_days = 16'(s5_quad) * 16'(DaysPerQuad);
  assign qd_full   = s5_days - quad_days;
  assign hour_prod = 27'(s5_tod[16:4]) * 27'(RecipHour);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_qd   <= qd_full[10:0];
      s6_hour <= hour_prod[25:21];
      s6_tod  <= s5_tod;
      s6_quad <= s5_quad;
      s6_ms   <= s5_ms;
    end
  end

  // ---------------------------------------------------------------- stage 7
  // Year inside the block (capped at the leap year), day of year, seconds of hour
  logic [1:0]  yidx;
  logic [10:0] yday_full;
  logic [16:0] hour_secs;
  logic [16:0] rem_full;
  logic [1:0]  s7_yidx;
  logic [8:0]  s7_yday0;
  logic [YearW-1:0] s7_year;
  logic [11:0] s7_rem;
  logic [HourW-1:0] s7_hour;
  logic [MsecW-1:0] s7_ms;

  always_comb begin
    if (s6_qd >= 11'(MaxYearIdx * DaysPerYear)) begin
      yidx = 2'd3;
    end else if (s6_qd >= 11'(2 * DaysPerYear)) begin
      yidx = 2'd2;
    end else if (s6_qd >= 11'(DaysPerYear)) begin
      yidx = 2'd1;
    end else begin
      yidx = 2'd0;
    end
    yday_full = s6_qd - 11'(yidx) * 11'(DaysPerYear);
    hour_secs = 17'(s6_hour) * 17'(SecPerHour);
    rem_full  = s6_tod - hour_secs;
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s7_yidx  <= yidx;
      s7_yday0 <= yday_full[8:0];
      s7_year  <= YearW'(BaseYear) + YearW'({s6_quad, 2'b00}) + YearW'(yidx);
      s7_rem   <= rem_full[11:0];
      s7_hour  <= s6_hour;
      s7_ms    <= s6_ms;
    end
  end

  // ---------------------------------------------------------------- stage 8
  // Century of the year and minute
  logic [20:0] cent_prod;
  logic [20:0] min_prod;
  logic [5:0]  s8_cent;
  logic [MinuteW-1:0] s8_min;
  logic [1:0]  s8_yidx;
  logic [8:0]  s8_yday0;
  logic [YearW-1:0] s8_year;
  logic [11:0] s8_rem;
  logic [HourW-1:0] s8_hour;
  logic [MsecW-1:0] s8_ms;

  assign cent_prod = 21'(s7_year[11:2]) * 21'(RecipCentury);
  assign min_prod  = 21'(s7_rem[11:2]) * 21'(RecipMin);

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s8_cent  <= cent_prod[20:15];
      s8_min   <= min_prod[19:14];
      s8_yidx  <= s7_yidx;
      s8_yday0 <= s7_yday0;
      s8_year  <= s7_year;
      s8_rem   <= s7_rem;
      s8_hour  <= s7_hour;
      s8_ms    <= s7_ms;
    end
  end

  // ---------------------------------------------------------------- stage 9
  // Leap-year rule and the February correction
  logic        cent_year;
  logic        is_leap;
  logic [8:0]  yday;
  logic [8:0]  yday_adj;
  logic [11:0] min_secs;
  logic [11:0] sec_full;
  logic        s9_feb29;
  logic [8:0]  s9_yday;
  logic [YearW-1:0] s9_year;
  logic [HourW-1:0] s9_hour;
  logic [MinuteW-1:0] s9_min;
  logic [SecondW-1:0] s9_sec;
  logic [MsecW-1:0] s9_ms;

  always_comb begin
    cent_year = (YearW'(s8_cent) * YearW'(100)) == s8_year;
    // Century years are leap only when divisible by 400
    is_leap   = (s8_yidx == 2'(MaxYearIdx)) && !(cent_year && (s8_cent[1:0] != 2'd0));
    yday      = s8_yday0 + 9'd1;
    yday_adj  = (is_leap && yday > 9'd60) ? yday - 9'd1 : yday;
    if (yday_adj > 9'(DaysPerYear)) begin
      yday_adj = 9'(DaysPerYear);
    end
    min_secs = 12'(s8_min) * 12'(SecPerMin);
    sec_full = s8_rem - min_secs;
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s9_feb29 <= is_leap && (yday == 9'd60);
      s9_yday  <= yday_adj;
      s9_year  <= s8_year;
      s9_hour  <= s8_hour;
      s9_min   <= s8_min;
      s9_sec   <= sec_full[SecondW-1:0];
      s9_ms    <= s8_ms;
    end
  end

  // ---------------------------------------------------------------- stage 10
  // Month search over the cumulative table, then the output register
  logic [MonthW-1:0] mon_sel;
  logic [DayW-1:0]   day_sel;
  logic [8:0]        day_full;

  always_comb begin
    mon_sel = MonthW'(1);
    for (int m = 1; m < 12; m++) begin
      if (s9_yday > cum_days(4'(m))) begin
        mon_sel = mon_sel + MonthW'(1);
      end
    end
    day_full = s9_yday - cum_days(mon_sel - MonthW'(1));
    day_sel  = day_full[DayW-1:0];
    if (s9_feb29) begin
      mon_sel = MonthW'(2);
      day_sel = DayW'(29);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      year         <= s9_year;
      month        <= mon_sel;
      day_of_month <= day_sel;
      hour         <= s9_hour;
      minute       <= s9_min;
      second       <= s9_sec;
      millisecond  <= s9_ms;
    end
  end

  // ---------------------------------------------------------------- checks
  // A draining output never holds off the input
  a_no_stall_when_draining: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1))
    else $error("month or day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59
                   && millisecond <= 10'd999))
    else $error("time of day out of range");

  // February 29 only in a year divisible by four
  a_feb29_leap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && month == 4'd2 && day_of_month == 5'd29) |-> (year[1:0] == 2'd0))
    else $error("February 29 in a common year");

endmodule
